// ===== rtl/core/shutter_position_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Shutter position controller assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHUTTER_POSITION_CONTROLLER_DEFINES_SVH
`define SHUTTER_POSITION_CONTROLLER_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define SPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after a reset edge
`define SPC_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// Shutter position controller package
// Command codes, register indexes, queue entry and result types.
// ----------------------------------------------------------------------------
package spc_pkg;

   // command codes on req_cmd
   localparam logic [3:0] CMD_TICK         = 4'd0;
   localparam logic [3:0] CMD_MANUAL_UP    = 4'd1;
   localparam logic [3:0] CMD_MANUAL_DOWN  = 4'd2;
   localparam logic [3:0] CMD_MANUAL_STOP  = 4'd3;
   localparam logic [3:0] CMD_AUTO_ON      = 4'd4;
   localparam logic [3:0] CMD_AUTO_OFF     = 4'd5;
   localparam logic [3:0] CMD_CAL_UP       = 4'd6;
   localparam logic [3:0] CMD_CAL_DOWN     = 4'd7;
   localparam logic [3:0] CMD_CAL_STOP     = 4'd8;
   localparam logic [3:0] CMD_UPPER_SET    = 4'd9;
   localparam logic [3:0] CMD_UPPER_DONE   = 4'd10;
   localparam logic [3:0] CMD_BOTTOM_SET   = 4'd11;
   localparam logic [3:0] CMD_LIGHT_SAMPLE = 4'd12;

   // configuration register indexes
   localparam logic [2:0] CSR_LOW_FRACTION  = 3'd0;
   localparam logic [2:0] CSR_MID_FRACTION  = 3'd1;
   localparam logic [2:0] CSR_HIGH_FRACTION = 3'd2;
   localparam logic [2:0] CSR_MID_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_HIGH_THRESHOLD = 3'd4;

   localparam logic [7:0]  LOW_FRACTION_RESET   = 8'd77;
   localparam logic [7:0]  MID_FRACTION_RESET   = 8'd154;
   localparam logic [7:0]  HIGH_FRACTION_RESET  = 8'd230;
   localparam logic [15:0] MID_THRESHOLD_RESET  = 16'd400;
   localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd1000;

   localparam int unsigned LUX_BITS   = 16;
   localparam int unsigned SUM_BITS   = 24;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TICK,
      OP_MANUAL,
      OP_AUTO,
      OP_CAL,
      OP_UPPER_SET,
      OP_UPPER_DONE,
      OP_BOTTOM_SET,
      OP_SAMPLE
   } op_type;

   typedef struct packed {
      op_type              op;
      dir_type             dir;
      logic                auto_on;
      logic [LUX_BITS-1:0] lux;
   } entry_type;

   typedef struct packed {
      logic [1:0] manual_step;
      logic [1:0] calibration_step;
      logic [1:0] auto_step;
      logic       auto_off_notice;
      logic       bottom_done_notice;
      logic       upper_done_notice;
      logic [7:0] shutter_position;
      logic [7:0] travel_limit;
      logic       is_calibrated;
      logic       auto_active;
   } result_type;

endpackage

// ===== rtl/core/shutter_position_controller.sv =====
// ----------------------------------------------------------------------------
// Shutter position controller
// Stepper sequencer for a roller shutter: manual, calibration and
// light-driven automatic moves, one result transaction per command.
// ----------------------------------------------------------------------------
//   channel   direction   handshake                  payload
//   req       in          req_valid / req_stall      cmd, lux
//   rsp       out         rsp_valid / rsp_stall      step pulses, notices, state
//   csr       in          csr_write_enable           csr_index, csr_write_data
//
// One command per cycle sustained while the result channel is not stalled;
// an accepted command enters the queue, then its result the result register.
// req_stall rises only when the two-entry command queue is full.
// Synchronous reset sets control state and register defaults at once.
// A stalled result holds while later commands wait in the queue.
// ----------------------------------------------------------------------------
module shutter_position_controller #(
   parameter int unsigned SAMPLES_PER_MEAN = 250,
   parameter int unsigned POSITION_BITS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_cmd,
   input  logic [15:0] req_lux,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_manual_step,
   output logic [1:0]  rsp_calibration_step,
   output logic [1:0]  rsp_auto_step,
   output logic        rsp_auto_off_notice,
   output logic        rsp_bottom_done_notice,
   output logic        rsp_upper_done_notice,
   output logic [7:0]  rsp_shutter_position,
   output logic [7:0]  rsp_travel_limit,
   output logic        rsp_is_calibrated,
   output logic        rsp_auto_active,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic                 push_valid, push_ready;
   spc_pkg::entry_type   push_entry, pop_entry;
   logic                 pop_valid, pop_ready;
   spc_pkg::result_type  rsp_data;

   spc_front u_front (
      .req_valid  (req_valid),
      .req_cmd    (req_cmd),
      .req_lux    (req_lux),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   spc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   spc_back #(
      .SAMPLES_PER_MEAN (SAMPLES_PER_MEAN),
      .POSITION_BITS    (POSITION_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   assign req_stall              = !push_ready;
   assign rsp_manual_step        = rsp_data.manual_step;
   assign rsp_calibration_step   = rsp_data.calibration_step;
   assign rsp_auto_step          = rsp_data.auto_step;
   assign rsp_auto_off_notice    = rsp_data.auto_off_notice;
   assign rsp_bottom_done_notice = rsp_data.bottom_done_notice;
   assign rsp_upper_done_notice  = rsp_data.upper_done_notice;
   assign rsp_shutter_position   = rsp_data.shutter_position;
   assign rsp_travel_limit       = rsp_data.travel_limit;
   assign rsp_is_calibrated      = rsp_data.is_calibrated;
   assign rsp_auto_active        = rsp_data.auto_active;

endmodule

// ===== rtl/core/spc_front.sv =====
// ----------------------------------------------------------------------------
// Shutter position controller front end
// Classifies each command into an operation and a direction for the queue.
// ----------------------------------------------------------------------------
module spc_front (
   input  logic                         req_valid,
   input  logic [3:0]                   req_cmd,
   input  logic [spc_pkg::LUX_BITS-1:0] req_lux,
   output logic                         push_valid,
   output spc_pkg::entry_type           push_entry
);

   always_comb begin
      push_entry.op      = spc_pkg::OP_NONE;
      push_entry.dir     = spc_pkg::DIR_NONE;
      push_entry.auto_on = 1'b0;
      push_entry.lux     = req_lux;
      unique case (req_cmd)
         spc_pkg::CMD_TICK:         push_entry.op = spc_pkg::OP_TICK;
         spc_pkg::CMD_MANUAL_UP: begin
            push_entry.op  = spc_pkg::OP_MANUAL;
            push_entry.dir = spc_pkg::DIR_UP;
         end
         spc_pkg::CMD_MANUAL_DOWN: begin
            push_entry.op  = spc_pkg::OP_MANUAL;
            push_entry.dir = spc_pkg::DIR_DOWN;
         end
         spc_pkg::CMD_MANUAL_STOP:  push_entry.op = spc_pkg::OP_MANUAL;
         spc_pkg::CMD_AUTO_ON: begin
            push_entry.op      = spc_pkg::OP_AUTO;
            push_entry.auto_on = 1'b1;
         end
         spc_pkg::CMD_AUTO_OFF:     push_entry.op = spc_pkg::OP_AUTO;
         spc_pkg::CMD_CAL_UP: begin
            push_entry.op  = spc_pkg::OP_CAL;
            push_entry.dir = spc_pkg::DIR_UP;
         end
         spc_pkg::CMD_CAL_DOWN: begin
            push_entry.op  = spc_pkg::OP_CAL;
            push_entry.dir = spc_pkg::DIR_DOWN;
         end
         spc_pkg::CMD_CAL_STOP:     push_entry.op = spc_pkg::OP_CAL;
         spc_pkg::CMD_UPPER_SET:    push_entry.op = spc_pkg::OP_UPPER_SET;
         spc_pkg::CMD_UPPER_DONE:   push_entry.op = spc_pkg::OP_UPPER_DONE;
         spc_pkg::CMD_BOTTOM_SET:   push_entry.op = spc_pkg::OP_BOTTOM_SET;
         spc_pkg::CMD_LIGHT_SAMPLE: push_entry.op = spc_pkg::OP_SAMPLE;
         default:                   push_entry.op = spc_pkg::OP_NONE;
      endcase
   end

   assign push_valid = req_valid;

endmodule

// ===== rtl/core/spc_queue.sv =====
// ----------------------------------------------------------------------------
// Shutter position controller command queue
// Short FIFO of classified commands between front end and execution.
// ----------------------------------------------------------------------------
module spc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  spc_pkg::entry_type   push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output spc_pkg::entry_type   pop_entry
);

   localparam int unsigned PTR_BITS = (spc_pkg::QUEUE_DEPTH > 1) ?
                                      $clog2(spc_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(spc_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(spc_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(spc_pkg::QUEUE_DEPTH);

   spc_pkg::entry_type  entries_ff [spc_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready    = (count_ff != FULL_CNT);
   assign pop_valid     = (count_ff != '0);
   assign push          = push_valid && push_ready;
   assign pop           = pop_valid && pop_ready;
   assign pop_entry     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/spc_back.sv =====
// ----------------------------------------------------------------------------
// Shutter position controller execution unit
// Applies queued commands to the shutter state and registers one result each.
// ----------------------------------------------------------------------------
module spc_back #(
   parameter int unsigned SAMPLES_PER_MEAN = 250,
   parameter int unsigned POSITION_BITS    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  spc_pkg::entry_type           pop_entry,
   input  logic                         csr_write_enable,
   input  logic [2:0]                   csr_index,
   input  logic [15:0]                  csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output spc_pkg::result_type          rsp_data
);

   localparam int unsigned PB = POSITION_BITS;
   localparam int unsigned PW = POSITION_BITS + 8;
   localparam int unsigned SB = spc_pkg::SUM_BITS;
   localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
   localparam logic [7:0]    SPM     = 8'(SAMPLES_PER_MEAN);
   localparam logic [SB-1:0] MID_SCALED_RESET =
      SB'(spc_pkg::MID_THRESHOLD_RESET * SAMPLES_PER_MEAN);
   localparam logic [SB-1:0] HIGH_SCALED_RESET =
      SB'(spc_pkg::HIGH_THRESHOLD_RESET * SAMPLES_PER_MEAN);

   // configuration; thresholds are kept already scaled by the window length
   logic [7:0]    low_frac_ff, mid_frac_ff, high_frac_ff;
   logic [SB-1:0] mid_scaled_ff, high_scaled_ff;
   logic [SB-1:0] csr_scaled;

   spc_pkg::dir_type manual_mode_ff, manual_mode_in;
   spc_pkg::dir_type cal_mode_ff, cal_mode_in;
   logic             auto_enabled_ff, auto_enabled_in;
   logic             upper_marked_ff, upper_marked_in;
   logic             calibrated_ff, calibrated_in;
   logic             finish_pending_ff, finish_pending_in;
   logic             auto_moving_ff, auto_moving_in;
   logic [PB-1:0]    position_ff, position_in;
   logic [PB-1:0]    max_position_ff, max_position_in;
   logic [PB-1:0]    auto_target_ff, auto_target_in;
   logic [SB-1:0]    light_sum_ff, light_sum_in;
   logic [7:0]       sample_count_ff, sample_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   spc_pkg::result_type rsp_ff, rsp_in;
   logic                fire;

   assign pop_ready     = !rsp_valid_ff || !rsp_stall;
   assign fire          = pop_valid && pop_ready;
   assign csr_scaled    = SB'(csr_write_data) * SB'(SPM);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_frac_ff    <= spc_pkg::LOW_FRACTION_RESET;
         mid_frac_ff    <= spc_pkg::MID_FRACTION_RESET;
         high_frac_ff   <= spc_pkg::HIGH_FRACTION_RESET;
         mid_scaled_ff  <= MID_SCALED_RESET;
         high_scaled_ff <= HIGH_SCALED_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            spc_pkg::CSR_LOW_FRACTION:   low_frac_ff    <= csr_write_data[7:0];
            spc_pkg::CSR_MID_FRACTION:   mid_frac_ff    <= csr_write_data[7:0];
            spc_pkg::CSR_HIGH_FRACTION:  high_frac_ff   <= csr_write_data[7:0];
            spc_pkg::CSR_MID_THRESHOLD:  mid_scaled_ff  <= csr_scaled;
            spc_pkg::CSR_HIGH_THRESHOLD: high_scaled_ff <= csr_scaled;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [SB:0]      sum_wide;
      logic [7:0]       frac;
      logic [PW-1:0]    product;
      logic [15:0]      pos_wide;
      logic [15:0]      max_wide;

      manual_mode_in    = manual_mode_ff;
      cal_mode_in       = cal_mode_ff;
      auto_enabled_in   = auto_enabled_ff;
      upper_marked_in   = upper_marked_ff;
      calibrated_in     = calibrated_ff;
      finish_pending_in = finish_pending_ff;
      auto_moving_in    = auto_moving_ff;
      position_in       = position_ff;
      max_position_in   = max_position_ff;
      auto_target_in    = auto_target_ff;
      light_sum_in      = light_sum_ff;
      sample_count_in   = sample_count_ff;
      rsp_in            = '0;
      sum_wide          = '0;
      frac              = low_frac_ff;
      product           = '0;

      if (fire) begin
         unique case (pop_entry.op)
            spc_pkg::OP_TICK: begin
               // manual rule
               if (manual_mode_ff == spc_pkg::DIR_UP && position_in != '0 &&
                   !auto_enabled_ff && calibrated_ff) begin
                  position_in = position_in - 1'b1;
                  rsp_in.manual_step = spc_pkg::DIR_UP;
               end else if (manual_mode_ff == spc_pkg::DIR_DOWN &&
                            position_in < max_position_ff &&
                            !auto_enabled_ff && calibrated_ff) begin
                  if (position_in != POS_MAX) position_in = position_in + 1'b1;
                  rsp_in.manual_step = spc_pkg::DIR_DOWN;
               end
               // end stop
               if (position_in == max_position_ff || position_in == '0) begin
                  manual_mode_in = spc_pkg::DIR_NONE;
               end
               // calibration move; before the upper mark, pin to the top
               if (cal_mode_ff != spc_pkg::DIR_NONE) begin
                  rsp_in.calibration_step = cal_mode_ff;
                  priority if (!upper_marked_ff) begin
                     position_in = '0;
                  end else if (cal_mode_ff == spc_pkg::DIR_DOWN) begin
                     if (position_in != POS_MAX) position_in = position_in + 1'b1;
                  end else begin
                     if (position_in != '0) position_in = position_in - 1'b1;
                  end
                  calibrated_in = 1'b0;
               end
               // calibration finish
               if (finish_pending_ff) begin
                  rsp_in.bottom_done_notice = 1'b1;
                  rsp_in.upper_done_notice  = 1'b1;
                  max_position_in   = position_in;
                  calibrated_in     = 1'b1;
                  upper_marked_in   = 1'b0;
                  finish_pending_in = 1'b0;
               end
               // one automatic step toward the target
               if (auto_enabled_ff && auto_moving_ff) begin
                  if (position_in < auto_target_ff) begin
                     if (position_in != POS_MAX) position_in = position_in + 1'b1;
                     rsp_in.auto_step = spc_pkg::DIR_DOWN;
                  end else if (position_in > auto_target_ff) begin
                     if (position_in != '0) position_in = position_in - 1'b1;
                     rsp_in.auto_step = spc_pkg::DIR_UP;
                  end
                  if (position_in == auto_target_ff) auto_moving_in = 1'b0;
               end
            end
            spc_pkg::OP_MANUAL, spc_pkg::OP_CAL: begin
               if (pop_entry.op == spc_pkg::OP_MANUAL) begin
                  manual_mode_in = pop_entry.dir;
               end else begin
                  cal_mode_in = pop_entry.dir;
               end
               auto_enabled_in        = 1'b0;
               auto_moving_in         = 1'b0;
               rsp_in.auto_off_notice = 1'b1;
            end
            spc_pkg::OP_AUTO: begin
               manual_mode_in  = spc_pkg::DIR_NONE;
               auto_enabled_in = pop_entry.auto_on;
               if (!pop_entry.auto_on) auto_moving_in = 1'b0;
            end
            spc_pkg::OP_UPPER_SET: begin
               upper_marked_in = 1'b1;
               cal_mode_in     = spc_pkg::DIR_NONE;
            end
            spc_pkg::OP_UPPER_DONE: upper_marked_in = 1'b0;
            spc_pkg::OP_BOTTOM_SET: begin
               if (upper_marked_ff) begin
                  finish_pending_in = 1'b1;
               end else begin
                  rsp_in.bottom_done_notice = 1'b1;
               end
            end
            spc_pkg::OP_SAMPLE: begin
               if (auto_enabled_ff) begin
                  sum_wide        = {1'b0, light_sum_ff} + (SB + 1)'(pop_entry.lux);
                  light_sum_in    = sum_wide[SB] ? {SB{1'b1}} : sum_wide[SB-1:0];
                  sample_count_in = sample_count_ff + 1'b1;
                  // window end: pick the level and set a new target
                  if (sample_count_in == SPM) begin
                     priority if (light_sum_in >= high_scaled_ff) begin
                        frac = high_frac_ff;
                     end else if (light_sum_in >= mid_scaled_ff) begin
                        frac = mid_frac_ff;
                     end else begin
                        frac = low_frac_ff;
                     end
                     product         = PW'(max_position_ff) * PW'(frac);
                     auto_target_in  = product[PW-1:8];
                     auto_moving_in  = 1'b1;
                     light_sum_in    = '0;
                     sample_count_in = '0;
                  end
               end
            end
            default: ;
         endcase
      end

      pos_wide = 16'(position_in);
      max_wide = 16'(max_position_in);
      rsp_in.shutter_position = pos_wide[7:0];
      rsp_in.travel_limit     = max_wide[7:0];
      rsp_in.is_calibrated    = calibrated_in;
      rsp_in.auto_active      = auto_enabled_in;
   end

   always_comb begin
      priority if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manual_mode_ff    <= spc_pkg::DIR_NONE;
         cal_mode_ff       <= spc_pkg::DIR_NONE;
         auto_enabled_ff   <= 1'b0;
         upper_marked_ff   <= 1'b0;
         calibrated_ff     <= 1'b0;
         finish_pending_ff <= 1'b0;
         auto_moving_ff    <= 1'b0;
         position_ff       <= '0;
         max_position_ff   <= '0;
         auto_target_ff    <= '0;
         light_sum_ff      <= '0;
         sample_count_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         manual_mode_ff    <= manual_mode_in;
         cal_mode_ff       <= cal_mode_in;
         auto_enabled_ff   <= auto_enabled_in;
         upper_marked_ff   <= upper_marked_in;
         calibrated_ff     <= calibrated_in;
         finish_pending_ff <= finish_pending_in;
         auto_moving_ff    <= auto_moving_in;
         position_ff       <= position_in;
         max_position_ff   <= max_position_in;
         auto_target_ff    <= auto_target_in;
         light_sum_ff      <= light_sum_in;
         sample_count_ff   <= sample_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // hold the result while stalled
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/spc_checker.sv =====
// ----------------------------------------------------------------------------
// Shutter position controller port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "shutter_position_controller_defines.svh"

module spc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_manual_step,
   input logic [1:0]  rsp_auto_step,
   input logic        rsp_auto_off_notice,
   input logic [7:0]  rsp_shutter_position,
   input logic        rsp_auto_active
);

   logic       rsp_wait, one_mover, off_seen, auto_quiet;
   logic [10:0] rsp_watch;

   assign rsp_wait   = rsp_valid && rsp_stall;
   assign rsp_watch  = {rsp_valid, rsp_shutter_position, rsp_auto_step};
   assign one_mover  = (rsp_manual_step == spc_pkg::DIR_NONE) ||
                       (rsp_auto_step == spc_pkg::DIR_NONE);
   assign off_seen   = rsp_valid && rsp_auto_off_notice;
   assign auto_quiet = !rsp_auto_active && (rsp_auto_step == spc_pkg::DIR_NONE);

   // a stalled result transaction holds
   `SPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, $stable(rsp_watch), "held result moved")

   `SPC_ASSERT_AFTER_RESET(a_rsp_reset, clock, reset, !rsp_valid, "result valid after reset")

   // manual steps need automatic mode off, automatic steps need it on: one source
   `SPC_ASSERT_NOW(a_step_excl, clock, reset, rsp_valid, one_mover, "step from two sources")

   `SPC_ASSERT_NOW(a_off_notice, clock, reset, off_seen, auto_quiet, "auto on after forced off")

endmodule

bind shutter_position_controller spc_checker u_spc_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shutter position controller testbench
// Drives command transactions with random gaps against a randomly stalled
// result channel. A scoreboard tracks the shutter state, predicts one result
// per accepted command and checks every result field in order. The run moves
// through several register settings: reset values, all zero, all ones and
// random ones.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned SAMPLES_PER_MEAN = 250;
   localparam int unsigned RANDOM_ITEMS     = 1900;
   localparam int unsigned PHASES           = 5;
   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int unsigned MAX_REPORTS      = 10;
   localparam int unsigned DRAIN_CYCLES     = 4;
   localparam logic [3:0]  CMD_SPARE_LOW    = 4'd13;
   localparam logic [3:0]  CMD_SPARE_HIGH   = 4'd15;

   class shutter_scoreboard;
      bit [7:0]          low_fraction   = spc_pkg::LOW_FRACTION_RESET;
      bit [7:0]          mid_fraction   = spc_pkg::MID_FRACTION_RESET;
      bit [7:0]          high_fraction  = spc_pkg::HIGH_FRACTION_RESET;
      bit [15:0]         mid_threshold  = spc_pkg::MID_THRESHOLD_RESET;
      bit [15:0]         high_threshold = spc_pkg::HIGH_THRESHOLD_RESET;
      spc_pkg::dir_type  manual_mode      = spc_pkg::DIR_NONE;
      spc_pkg::dir_type  calibration_mode = spc_pkg::DIR_NONE;
      bit                auto_enabled, upper_marked, calibrated;
      bit                finish_pending, auto_moving;
      bit [7:0]          position, max_position, sample_count, auto_target;
      bit [spc_pkg::SUM_BITS-1:0] light_sum;
      spc_pkg::result_type expected_results[$];
      int unsigned       error_count;
      int unsigned       result_count;

      function void set_register(logic [2:0] idx, logic [15:0] data);
         case (idx)
            spc_pkg::CSR_LOW_FRACTION:   low_fraction   = data[7:0];
            spc_pkg::CSR_MID_FRACTION:   mid_fraction   = data[7:0];
            spc_pkg::CSR_HIGH_FRACTION:  high_fraction  = data[7:0];
            spc_pkg::CSR_MID_THRESHOLD:  mid_threshold  = data;
            spc_pkg::CSR_HIGH_THRESHOLD: high_threshold = data;
            default: ;
         endcase
      endfunction

      // up moves toward zero, down away from it; both saturate
      function void move_up();
         if (position != '0) position--;
      endfunction

      function void move_down();
         if (position != '1) position++;
      endfunction

      function void note_command(logic [3:0] cmd, logic [15:0] lux);
         spc_pkg::result_type r;
         int unsigned sum;
         bit [7:0]    frac;
         bit [15:0]   product;
         r = '0;
         case (cmd)
            spc_pkg::CMD_TICK: begin
               if (manual_mode == spc_pkg::DIR_UP && position > 0 &&
                   !auto_enabled && calibrated) begin
                  move_up();
                  r.manual_step = spc_pkg::DIR_UP;
               end else if (manual_mode == spc_pkg::DIR_DOWN && position < max_position &&
                            !auto_enabled && calibrated) begin
                  move_down();
                  r.manual_step = spc_pkg::DIR_DOWN;
               end
               if (position == max_position || position == 0) manual_mode = spc_pkg::DIR_NONE;
               if (calibration_mode != spc_pkg::DIR_NONE) begin
                  r.calibration_step = calibration_mode;
                  if (!upper_marked) position = '0;
                  else if (calibration_mode == spc_pkg::DIR_DOWN) move_down();
                  else move_up();
                  calibrated = 1'b0;
               end
               if (finish_pending) begin
                  r.bottom_done_notice = 1'b1;
                  r.upper_done_notice  = 1'b1;
                  max_position   = position;
                  calibrated     = 1'b1;
                  upper_marked   = 1'b0;
                  finish_pending = 1'b0;
               end
               if (auto_enabled && auto_moving) begin
                  if (position < auto_target) begin
                     move_down();
                     r.auto_step = spc_pkg::DIR_DOWN;
                  end else if (position > auto_target) begin
                     move_up();
                     r.auto_step = spc_pkg::DIR_UP;
                  end
                  if (position == auto_target) auto_moving = 1'b0;
               end
            end
            spc_pkg::CMD_MANUAL_UP, spc_pkg::CMD_MANUAL_DOWN, spc_pkg::CMD_MANUAL_STOP,
            spc_pkg::CMD_CAL_UP, spc_pkg::CMD_CAL_DOWN, spc_pkg::CMD_CAL_STOP: begin
               case (cmd)
                  spc_pkg::CMD_MANUAL_UP:   manual_mode = spc_pkg::DIR_UP;
                  spc_pkg::CMD_MANUAL_DOWN: manual_mode = spc_pkg::DIR_DOWN;
                  spc_pkg::CMD_MANUAL_STOP: manual_mode = spc_pkg::DIR_NONE;
                  spc_pkg::CMD_CAL_UP:      calibration_mode = spc_pkg::DIR_UP;
                  spc_pkg::CMD_CAL_DOWN:    calibration_mode = spc_pkg::DIR_DOWN;
                  default:                  calibration_mode = spc_pkg::DIR_NONE;
               endcase
               // any move command drops automatic mode, even when it was off
               auto_enabled = 1'b0;
               auto_moving  = 1'b0;
               r.auto_off_notice = 1'b1;
            end
            spc_pkg::CMD_AUTO_ON, spc_pkg::CMD_AUTO_OFF: begin
               manual_mode  = spc_pkg::DIR_NONE;
               auto_enabled = (cmd == spc_pkg::CMD_AUTO_ON);
               if (!auto_enabled) auto_moving = 1'b0;
            end
            spc_pkg::CMD_UPPER_SET: begin
               upper_marked     = 1'b1;
               calibration_mode = spc_pkg::DIR_NONE;
            end
            spc_pkg::CMD_UPPER_DONE: upper_marked = 1'b0;
            spc_pkg::CMD_BOTTOM_SET: begin
               if (upper_marked) finish_pending = 1'b1;
               else r.bottom_done_notice = 1'b1;
            end
            spc_pkg::CMD_LIGHT_SAMPLE: begin
               if (auto_enabled) begin
                  sum = light_sum + lux;
                  if (sum > (1 << spc_pkg::SUM_BITS) - 1) light_sum = '1;
                  else light_sum = sum[spc_pkg::SUM_BITS-1:0];
                  sample_count++;
                  if (sample_count == SAMPLES_PER_MEAN) begin
                     if (light_sum >= int'(high_threshold) * SAMPLES_PER_MEAN)
                        frac = high_fraction;
                     else if (light_sum >= int'(mid_threshold) * SAMPLES_PER_MEAN)
                        frac = mid_fraction;
                     else
                        frac = low_fraction;
                     product      = max_position * frac;
                     auto_target  = product[15:8];
                     auto_moving  = 1'b1;
                     light_sum    = '0;
                     sample_count = '0;
                  end
               end
            end
            default: ;
         endcase
         r.shutter_position = position;
         r.travel_limit     = max_position;
         r.is_calibrated    = calibrated;
         r.auto_active      = auto_enabled;
         expected_results.push_back(r);
      endfunction

      function string describe(spc_pkg::result_type r);
         return $sformatf({"manual %0d cal %0d auto %0d off %0d bottom %0d upper %0d ",
                           "pos %0d limit %0d calibrated %0d auto_on %0d"},
                          r.manual_step, r.calibration_step, r.auto_step,
                          r.auto_off_notice, r.bottom_done_notice, r.upper_done_notice,
                          r.shutter_position, r.travel_limit, r.is_calibrated,
                          r.auto_active);
      endfunction

      function void check_result(spc_pkg::result_type got);
         spc_pkg::result_type want;
         string      fields;
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: result with nothing pending: %s", describe(got));
            return;
         end
         want   = expected_results.pop_front();
         fields = "";
         if (got.manual_step        !== want.manual_step)        fields = {fields, " manual_step"};
         if (got.calibration_step   !== want.calibration_step)   fields = {fields, " calibration_step"};
         if (got.auto_step          !== want.auto_step)          fields = {fields, " auto_step"};
         if (got.auto_off_notice    !== want.auto_off_notice)    fields = {fields, " auto_off_notice"};
         if (got.bottom_done_notice !== want.bottom_done_notice) fields = {fields, " bottom_done_notice"};
         if (got.upper_done_notice  !== want.upper_done_notice)  fields = {fields, " upper_done_notice"};
         if (got.shutter_position   !== want.shutter_position)   fields = {fields, " shutter_position"};
         if (got.travel_limit       !== want.travel_limit)       fields = {fields, " travel_limit"};
         if (got.is_calibrated      !== want.is_calibrated)      fields = {fields, " is_calibrated"};
         if (got.auto_active        !== want.auto_active)        fields = {fields, " auto_active"};
         if (fields != "") begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR: result %0d differs in%s\n  expected %s\n  actual   %s",
                        result_count, fields, describe(want), describe(got));
         end
         result_count++;
      endfunction
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [3:0]  req_cmd          = spc_pkg::CMD_TICK;
   logic [15:0] req_lux          = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [1:0]  rsp_manual_step;
   logic [1:0]  rsp_calibration_step;
   logic [1:0]  rsp_auto_step;
   logic        rsp_auto_off_notice;
   logic        rsp_bottom_done_notice;
   logic        rsp_upper_done_notice;
   logic [7:0]  rsp_shutter_position;
   logic [7:0]  rsp_travel_limit;
   logic        rsp_is_calibrated;
   logic        rsp_auto_active;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index        = spc_pkg::CSR_LOW_FRACTION;
   logic [15:0] csr_write_data   = '0;
   spc_pkg::result_type rsp_fields;

   shutter_scoreboard tracker;
   int unsigned       items_sent;
   int unsigned       cycle_count;
   int unsigned       calm_left;
   int unsigned       stall_left, free_left, stall_pick;
   bit                valid_held;

   assign rsp_fields = {rsp_manual_step, rsp_calibration_step, rsp_auto_step,
                        rsp_auto_off_notice, rsp_bottom_done_notice, rsp_upper_done_notice,
                        rsp_shutter_position, rsp_travel_limit, rsp_is_calibrated,
                        rsp_auto_active};

   shutter_position_controller dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_result(rsp_fields);
   end

   // mostly short stalls and short free stretches, a few long stalls, and now and then a long free stretch
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 5) free_left = $urandom_range(30, 120);
         else if (stall_pick < 60) free_left = $urandom_range(0, 4);
         else if (stall_pick < 92) stall_left = $urandom_range(1, 3);
         else stall_left = $urandom_range(8, 30);
         rsp_stall <= (stall_left > 0);
      end
   end

   function automatic logic [15:0] random_lux();
      return 16'($urandom);
   endfunction

   function automatic int unsigned sender_gap();
      int unsigned pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_command(input logic [3:0] cmd, input logic [15:0] lux);
      int unsigned gap;
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_lux   <= lux;
      do @(posedge clock); while (req_stall);
      tracker.note_command(cmd, lux);
      items_sent++;
      gap = sender_gap();
      valid_held = (gap == 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
      end
      while (tracker.expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
   endtask

   task automatic write_settings(input logic [7:0] low, input logic [7:0] mid,
                                 input logic [7:0] high, input logic [15:0] mid_lux,
                                 input logic [15:0] high_lux);
      // junk in the upper byte of the fraction writes must be dropped
      write_register(spc_pkg::CSR_LOW_FRACTION, {8'($urandom), low});
      write_register(spc_pkg::CSR_MID_FRACTION, {8'($urandom), mid});
      write_register(spc_pkg::CSR_HIGH_FRACTION, {8'($urandom), high});
      write_register(spc_pkg::CSR_MID_THRESHOLD, mid_lux);
      write_register(spc_pkg::CSR_HIGH_THRESHOLD, high_lux);
      for (int idx = int'(spc_pkg::CSR_HIGH_THRESHOLD) + 1; idx < (1 << $bits(csr_index));
           idx++)
         write_register(3'(idx), random_lux());
      csr_write_enable <= 1'b0;
   endtask

   // automatic mode on, usually one full averaging window, then ticks toward the target
   task automatic run_light_window();
      int unsigned mode, level, count, moves, cut;
      send_command(spc_pkg::CMD_AUTO_ON, random_lux());
      mode = $urandom_range(0, 5);
      case (mode)
         0: level = tracker.mid_threshold;
         1: level = tracker.high_threshold;
         2: level = (tracker.mid_threshold == 0) ? 0 : tracker.mid_threshold - 1;
         3: level = 0;
         default: level = 16'hFFFF;
      endcase
      count = SAMPLES_PER_MEAN - tracker.sample_count;
      // leave a partial window now and then
      if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
      repeat (count) begin
         if ($urandom_range(0, 29) == 0) send_command(spc_pkg::CMD_TICK, random_lux());
         send_command(spc_pkg::CMD_LIGHT_SAMPLE, (mode == 5) ? random_lux() : 16'(level));
      end
      moves = (tracker.position > tracker.auto_target) ?
              tracker.position - tracker.auto_target : tracker.auto_target - tracker.position;
      moves += $urandom_range(0, 3);
      cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, moves) : moves;
      repeat (cut) send_command(spc_pkg::CMD_TICK, random_lux());
      if (cut != moves) begin
         // interrupt the move, then check that ticks no longer step
         send_command($urandom_range(0, 1) ? spc_pkg::CMD_AUTO_OFF : spc_pkg::CMD_MANUAL_STOP,
                      random_lux());
         repeat ($urandom_range(1, 4)) send_command(spc_pkg::CMD_TICK, random_lux());
      end
      if ($urandom_range(0, 1)) send_command(spc_pkg::CMD_AUTO_OFF, random_lux());
   endtask

   task automatic run_calibration();
      int unsigned depth;
      if ($urandom_range(0, 7) != 0) send_command(spc_pkg::CMD_UPPER_SET, random_lux());
      // sometimes run far enough to hit the position ceiling
      depth = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 60);
      send_command(spc_pkg::CMD_CAL_DOWN, random_lux());
      repeat (depth) send_command(spc_pkg::CMD_TICK, random_lux());
      if ($urandom_range(0, 2) == 0) begin
         send_command(spc_pkg::CMD_CAL_UP, random_lux());
         repeat ($urandom_range(1, 20)) send_command(spc_pkg::CMD_TICK, random_lux());
      end
      send_command(($urandom_range(0, 3) == 0) ? spc_pkg::CMD_UPPER_SET : spc_pkg::CMD_CAL_STOP,
                   random_lux());
      if ($urandom_range(0, 7) == 0) send_command(spc_pkg::CMD_UPPER_DONE, random_lux());
      send_command(spc_pkg::CMD_BOTTOM_SET, random_lux());
      repeat ($urandom_range(1, 3)) send_command(spc_pkg::CMD_TICK, random_lux());
   endtask

   task automatic run_manual_move();
      send_command($urandom_range(0, 1) ? spc_pkg::CMD_MANUAL_UP : spc_pkg::CMD_MANUAL_DOWN,
                   random_lux());
      repeat (($urandom_range(0, 6) == 0) ? $urandom_range(100, 260) : $urandom_range(1, 25))
         send_command(spc_pkg::CMD_TICK, random_lux());
      if ($urandom_range(0, 1)) send_command(spc_pkg::CMD_MANUAL_STOP, random_lux());
   endtask

   initial begin
      int unsigned pick, random_start;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_settings(spc_pkg::LOW_FRACTION_RESET, spc_pkg::MID_FRACTION_RESET,
                     spc_pkg::HIGH_FRACTION_RESET, spc_pkg::MID_THRESHOLD_RESET,
                     spc_pkg::HIGH_THRESHOLD_RESET);

      send_command(spc_pkg::CMD_TICK, 16'h0000);
      send_command(CMD_SPARE_LOW, 16'hFFFF);
      send_command(CMD_SPARE_HIGH, 16'h0000);
      // notice is raised even though automatic mode is already off
      send_command(spc_pkg::CMD_MANUAL_UP, random_lux());
      send_command(spc_pkg::CMD_TICK, random_lux());
      send_command(spc_pkg::CMD_MANUAL_DOWN, random_lux());
      send_command(spc_pkg::CMD_MANUAL_STOP, random_lux());
      send_command(spc_pkg::CMD_AUTO_ON, random_lux());
      send_command(spc_pkg::CMD_LIGHT_SAMPLE, 16'hFFFF);
      send_command(spc_pkg::CMD_AUTO_OFF, random_lux());
      send_command(spc_pkg::CMD_LIGHT_SAMPLE, 16'h5A5A);
      send_command(spc_pkg::CMD_BOTTOM_SET, random_lux());
      // no upper mark: calibration tick forces position to zero
      send_command(spc_pkg::CMD_CAL_DOWN, random_lux());
      send_command(spc_pkg::CMD_TICK, random_lux());
      send_command(spc_pkg::CMD_UPPER_SET, random_lux());
      send_command(spc_pkg::CMD_UPPER_DONE, random_lux());
      send_command(spc_pkg::CMD_UPPER_SET, random_lux());
      send_command(spc_pkg::CMD_CAL_UP, random_lux());
      send_command(spc_pkg::CMD_TICK, random_lux());
      send_command(spc_pkg::CMD_CAL_DOWN, random_lux());
      repeat (3) send_command(spc_pkg::CMD_TICK, random_lux());
      send_command(spc_pkg::CMD_CAL_STOP, random_lux());
      send_command(spc_pkg::CMD_BOTTOM_SET, random_lux());
      send_command(spc_pkg::CMD_TICK, random_lux());

      random_start = items_sent;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         case (phase)
            0: write_settings(spc_pkg::LOW_FRACTION_RESET, spc_pkg::MID_FRACTION_RESET,
                              spc_pkg::HIGH_FRACTION_RESET, spc_pkg::MID_THRESHOLD_RESET,
                              spc_pkg::HIGH_THRESHOLD_RESET);
            1: write_settings('0, '0, '0, '0, '0);
            2: write_settings('1, '1, '1, '1, '1);
            3: write_settings(8'($urandom), 8'($urandom), 8'($urandom),
                              16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
            default: write_settings(8'($urandom), 8'($urandom), 8'($urandom),
                                    random_lux(), random_lux());
         endcase
         while (items_sent - random_start < (phase + 1) * RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) run_light_window();
            else if (pick < 38) run_calibration();
            else if (pick < 70) run_manual_move();
            else repeat ($urandom_range(1, 4)) send_command(4'($urandom), random_lux());
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.error_count == 0 && tracker.expected_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
